/* rtl/celtic_fractal_escape_time_assert.svh */
// Assertion macros shared by the escape-time block.
// Define ASSERT_OFF to compile every check away; no other dependencies.
`ifndef CELTIC_FRACTAL_ESCAPE_TIME_ASSERT_SVH
`define CELTIC_FRACTAL_ESCAPE_TIME_ASSERT_SVH
`ifndef ASSERT_OFF
// Same-cycle implication, disabled while reset is high
`define CFE_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);
// Next-cycle implication, disabled while reset is high
`define CFE_ASSERT_NXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);
`else
`define CFE_ASSERT_IMP(label, clk, rst, ante, cons, msg)
`define CFE_ASSERT_NXT(label, clk, rst, ante, cons, msg)
`endif
`endif

/* rtl/cfe_pkg.sv */
// Shared types, constants and helpers for the Celtic escape-time block.
// No dependencies; imported by the controller, datapath and top level.
`timescale 1ns / 1ps
`default_nettype none

package cfe_pkg;

  // Image geometry
  localparam int IMG_WIDTH  = 1024;
  localparam int IMG_HEIGHT = 1024;
  localparam int PIX_W      = 10;

  // Signed pixel offset wide enough for index minus half the image size
  localparam int GEO_W  = (IMG_WIDTH > IMG_HEIGHT) ? IMG_WIDTH : IMG_HEIGHT;
  localparam int DIFF_W = ((PIX_W > $clog2(GEO_W)) ? PIX_W : $clog2(GEO_W)) + 2;

  // Fixed-point format: signed Q4.28 in 32 bits
  localparam int Q_W       = 32;
  localparam int FRAC_BITS = 28;
  localparam int STEP_W    = 31;
  localparam int ITER_W    = 12;
  localparam logic signed [Q_W-1:0] Q_MAX = 32'sh7fff_ffff;
  localparam logic signed [Q_W-1:0] Q_MIN = 32'sh8000_0000;

  // Pixel mapping product and wide sum for saturation
  localparam int PROD_W = DIFF_W + Q_W;
  localparam int SAT_W  = 2 * Q_W;

  // Floored squares, their sum and the floored doubled cross product
  localparam int SQ_W    = 2 * Q_W - 1 - FRAC_BITS;
  localparam int MAG_W   = SQ_W + 1;
  localparam int CROSS_W = 2 * Q_W - (FRAC_BITS - 1);
  localparam logic [MAG_W-1:0] ESC_LIMIT = MAG_W'(4) << FRAC_BITS;

  // Configuration port
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;
  localparam logic [CFG_IDX_W-1:0] REG_STEP_RE   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_STEP_IM   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CENTER_RE = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_CENTER_IM = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_ITER  = 3'd4;

  // Register reset values
  localparam logic [STEP_W-1:0]     STEP_RST   = 31'd1048576;
  localparam logic signed [Q_W-1:0] CENTER_RST = 32'sd0;
  localparam logic [ITER_W-1:0]     ITER_RST   = 12'd64;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic take;      // latch the accepted pixel request
    logic map;       // form the offset-times-step products
    logic cadd;      // add the centre, saturate c, clear z and count
    logic mul;       // form squares and cross product of z
    logic step;      // write back the new z and bump the count
    logic out_load;  // move the finished result into the output register
  } cfe_cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic zero_limit;  // iteration limit is zero
    logic escape;      // |z|^2 exceeds 4 for the current z
    logic last;        // this step brings the count to the limit
  } cfe_stat_t;

  // Saturate a wide signed value to Q4.28
  function automatic logic signed [Q_W-1:0] sat_q(input logic signed [SAT_W-1:0] v);
    logic hi_ones;
    logic hi_zero;
    hi_ones = &v[SAT_W-1:Q_W-1];
    hi_zero = ~|v[SAT_W-1:Q_W-1];
    if (hi_ones || hi_zero) begin
      sat_q = v[Q_W-1:0];
    end else if (v[SAT_W-1]) begin
      sat_q = Q_MIN;
    end else begin
      sat_q = Q_MAX;
    end
  endfunction

endpackage

`default_nettype wire

/* rtl/cfe_ctrl.sv */
// Controller state machine for the Celtic escape-time block.
// Depends on cfe_pkg and the shared assertion macros.
`timescale 1ns / 1ps
`default_nettype none
`include "celtic_fractal_escape_time_assert.svh"

module cfe_ctrl
  import cfe_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      in_valid,
  output logic           in_stall,
  output logic           out_valid,
  input  wire logic      out_stall,
  input  wire cfe_stat_t stat,
  output cfe_cmd_t       cmd
);

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_MAP  = 6'b000010,
    S_CADD = 6'b000100,
    S_MUL  = 6'b001000,
    S_UPD  = 6'b010000,
    S_DONE = 6'b100000
  } state_t;

  state_t state;
  state_t state_next;
  logic   out_free;

  // Output register can take a result when empty or being drained
  assign out_free = !out_valid || !out_stall;
  assign in_stall = (state != S_IDLE);

  // Next state and commands
  always_comb begin
    state_next   = state;
    cmd          = '0;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.take   = 1'b1;
          state_next = S_MAP;
        end
      end
      S_MAP: begin
        cmd.map    = 1'b1;
        state_next = S_CADD;
      end
      S_CADD: begin
        cmd.cadd   = 1'b1;
        state_next = stat.zero_limit ? S_DONE : S_MUL;
      end
      S_MUL: begin
        cmd.mul    = 1'b1;
        state_next = S_UPD;
      end
      S_UPD: begin
        if (stat.escape) begin
          state_next = S_DONE;
        end else begin
          cmd.step   = 1'b1;
          state_next = stat.last ? S_DONE : S_MUL;
        end
      end
      S_DONE: begin
        if (out_free) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Output valid: set on load, drop once taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  `CFE_ASSERT_NXT(a_take_starts_map, clk, rst, state == S_IDLE && in_valid, state == S_MAP, "accepted request did not start mapping")
  `CFE_ASSERT_IMP(a_result_from_done, clk, rst, $rose(out_valid), $past(state == S_DONE), "result shown without finishing an item")
  `CFE_ASSERT_NXT(a_iterate_again, clk, rst, state == S_UPD && !stat.escape && !stat.last, state == S_MUL, "iteration loop left early")

endmodule

`default_nettype wire

/* rtl/cfe_dpath.sv */
// Datapath for the Celtic escape-time block: configuration registers,
// pixel mapping, the iteration unit and the output register. Uses cfe_pkg.
`timescale 1ns / 1ps
`default_nettype none
`include "celtic_fractal_escape_time_assert.svh"

module cfe_dpath
  import cfe_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data,
  input  wire logic [PIX_W-1:0]      pixel_col,
  input  wire logic [PIX_W-1:0]      pixel_row,
  input  wire cfe_cmd_t              cmd,
  output cfe_stat_t                  stat,
  output logic [PIX_W-1:0]           col_out,
  output logic [PIX_W-1:0]           row_out,
  output logic [ITER_W-1:0]          iter_count,
  output logic                       escaped
);

  // Configuration registers
  logic [STEP_W-1:0]     step_re;
  logic [STEP_W-1:0]     step_im;
  logic signed [Q_W-1:0] center_re;
  logic signed [Q_W-1:0] center_im;
  logic [ITER_W-1:0]     max_iter;

  // Request and working registers
  logic [PIX_W-1:0]         col_q;
  logic [PIX_W-1:0]         row_q;
  logic signed [PROD_W-1:0] prod_re;
  logic signed [PROD_W-1:0] prod_im;
  logic signed [Q_W-1:0]    c_re;
  logic signed [Q_W-1:0]    c_im;
  logic signed [Q_W-1:0]    zr;
  logic signed [Q_W-1:0]    zi;
  logic [ITER_W-1:0]        count;
  logic [SQ_W-1:0]          sq_re;
  logic [SQ_W-1:0]          sq_im;
  logic signed [CROSS_W-1:0] cross_q;

  // Combinational terms
  logic signed [DIFF_W-1:0]  d_col;
  logic signed [DIFF_W-1:0]  d_row;
  logic signed [PROD_W-1:0]  prod_re_next;
  logic signed [PROD_W-1:0]  prod_im_next;
  logic signed [SAT_W-1:0]   c_re_sum;
  logic signed [SAT_W-1:0]   c_im_sum;
  logic signed [SAT_W-1:0]   zr_sqr_full;
  logic signed [SAT_W-1:0]   zi_sqr_full;
  logic signed [SAT_W-1:0]   cross_full;
  logic [MAG_W-1:0]          mag;
  logic signed [MAG_W-1:0]   diff;
  logic signed [MAG_W-1:0]   diff_abs;
  logic signed [SAT_W-1:0]   zr_sum;
  logic signed [SAT_W-1:0]   zi_sum;
  logic [ITER_W:0]           count_inc;

  // Write configuration registers; unknown indexes are ignored
  always_ff @(posedge clk) begin
    if (rst) begin
      step_re   <= STEP_RST;
      step_im   <= STEP_RST;
      center_re <= CENTER_RST;
      center_im <= CENTER_RST;
      max_iter  <= ITER_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_STEP_RE:   step_re   <= cfg_data[STEP_W-1:0];
        REG_STEP_IM:   step_im   <= cfg_data[STEP_W-1:0];
        REG_CENTER_RE: center_re <= $signed(cfg_data[Q_W-1:0]);
        REG_CENTER_IM: center_im <= $signed(cfg_data[Q_W-1:0]);
        REG_MAX_ITER:  max_iter  <= cfg_data[ITER_W-1:0];
        default: ;
      endcase
    end
  end

  // Offset from the image centre times the per-axis step
  assign d_col = $signed({{(DIFF_W-PIX_W){1'b0}}, col_q}) - $signed(DIFF_W'(IMG_WIDTH / 2));
  assign d_row = $signed({{(DIFF_W-PIX_W){1'b0}}, row_q}) - $signed(DIFF_W'(IMG_HEIGHT / 2));
  assign prod_re_next = PROD_W'(d_col) * PROD_W'($signed({1'b0, step_re}));
  assign prod_im_next = PROD_W'(d_row) * PROD_W'($signed({1'b0, step_im}));

  // Add the centre at full width
  assign c_re_sum = SAT_W'(prod_re) + SAT_W'(center_re);
  assign c_im_sum = SAT_W'(prod_im) + SAT_W'(center_im);

  // Squares and cross product of z
  assign zr_sqr_full = SAT_W'(zr) * SAT_W'(zr);
  assign zi_sqr_full = SAT_W'(zi) * SAT_W'(zi);
  assign cross_full  = SAT_W'(zr) * SAT_W'(zi);

  // Escape test and Celtic update from the registered products
  assign mag      = {1'b0, sq_re} + {1'b0, sq_im};
  assign diff     = $signed({1'b0, sq_re}) - $signed({1'b0, sq_im});
  assign diff_abs = diff[MAG_W-1] ? -diff : diff;
  assign zr_sum   = SAT_W'(diff_abs) + SAT_W'(c_re);
  assign zi_sum   = SAT_W'(cross_q) + SAT_W'(c_im);

  assign count_inc       = {1'b0, count} + (ITER_W+1)'(1);
  assign stat.zero_limit = (max_iter == '0);
  assign stat.escape     = (mag > ESC_LIMIT);
  assign stat.last       = (count_inc == {1'b0, max_iter});

  // Hold the accepted pixel
  always_ff @(posedge clk) begin
    if (cmd.take) begin
      col_q <= pixel_col;
      row_q <= pixel_row;
    end
  end

  // Register the mapping products
  always_ff @(posedge clk) begin
    if (cmd.map) begin
      prod_re <= prod_re_next;
      prod_im <= prod_im_next;
    end
  end

  // Saturate c, clear z and count; then advance z one step at a time
  always_ff @(posedge clk) begin
    if (cmd.cadd) begin
      c_re  <= sat_q(c_re_sum);
      c_im  <= sat_q(c_im_sum);
      zr    <= '0;
      zi    <= '0;
      count <= '0;
    end else if (cmd.step) begin
      zr    <= sat_q(zr_sum);
      zi    <= sat_q(zi_sum);
      count <= count_inc[ITER_W-1:0];
    end
  end

  // Register floored squares and the doubled cross product
  always_ff @(posedge clk) begin
    if (cmd.mul) begin
      sq_re   <= zr_sqr_full[SAT_W-2:FRAC_BITS];
      sq_im   <= zi_sqr_full[SAT_W-2:FRAC_BITS];
      cross_q <= cross_full[SAT_W-1:FRAC_BITS-1];
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      col_out    <= col_q;
      row_out    <= row_q;
      iter_count <= count;
      escaped    <= (count < max_iter);
    end
  end

  `CFE_ASSERT_IMP(a_mul_below_limit, clk, rst, cmd.mul, count < max_iter, "iteration started at or past the limit")
  `CFE_ASSERT_IMP(a_load_within_limit, clk, rst, cmd.out_load, count <= max_iter, "result count beyond the limit")

endmodule

`default_nettype wire

/* rtl/celtic_fractal_escape_time.sv */
// Top level of the Celtic escape-time block: controller plus datapath.
// Depends on cfe_pkg, cfe_ctrl and cfe_dpath.
//
//   channel   handshake            payload
//   in        in_valid / in_stall  pixel_col, pixel_row
//   out       out_valid/ out_stall col_out, row_out, iter_count, escaped
//   cfg       cfg_we               cfg_index, cfg_data
//
// An accepted item is mapped, gets the centre added and iterates until it escapes or
// iter_count reaches the limit (a zero limit skips this), then enters the output
// register once free. An iteration is a step on the three 32x32 multipliers, then the
// add, saturate and escape compare. One item is in work at a time; the output
// register lets the next request in while a result waits under out_stall.
// Reset (synchronous, active high) empties the block and restores the registers.
`timescale 1ns / 1ps
`default_nettype none

module celtic_fractal_escape_time
  import cfe_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  in_valid,
  output logic                       in_stall,
  input  wire logic [PIX_W-1:0]      pixel_col,
  input  wire logic [PIX_W-1:0]      pixel_row,
  output logic                       out_valid,
  input  wire logic                  out_stall,
  output logic [PIX_W-1:0]           col_out,
  output logic [PIX_W-1:0]           row_out,
  output logic [ITER_W-1:0]          iter_count,
  output logic                       escaped,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data
);

  cfe_cmd_t  cmd;
  cfe_stat_t stat;

  // Sequence each request
  cfe_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .stat      (stat),
    .cmd       (cmd)
  );

  // Map, iterate and hold the result
  cfe_dpath u_dpath (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .pixel_col  (pixel_col),
    .pixel_row  (pixel_row),
    .cmd        (cmd),
    .stat       (stat),
    .col_out    (col_out),
    .row_out    (row_out),
    .iter_count (iter_count),
    .escaped    (escaped)
  );

endmodule

`default_nettype wire
